[src/rrpf_pkg.sv]
package rrpf_pkg;

    localparam int ANCHOR_COUNT = 6;
    localparam int TAG_SLOTS    = 4;

    localparam int PAYLOAD_LEN = 4 + 4 * ANCHOR_COUNT;
    localparam int FRAME_LEN   = PAYLOAD_LEN + 4;
    localparam int CNT_W       = $clog2(FRAME_LEN);
    localparam int AIDX_W      = (ANCHOR_COUNT > 1) ? $clog2(ANCHOR_COUNT) : 1;
    localparam int SLOT_W      = (TAG_SLOTS > 1) ? $clog2(TAG_SLOTS) : 1;

    localparam logic [7:0] MAGIC_HI  = 8'hA5;
    localparam logic [7:0] MAGIC_LO  = 8'h5A;
    localparam logic [7:0] TYPE_DATA = 8'h01;
    localparam logic [7:0] CRC_POLY  = 8'h07;
    localparam logic [7:0] FIRST_TAG_RESET = 8'd7;

    // byte positions inside a frame
    localparam int POS_MAGIC_HI = 0;
    localparam int POS_MAGIC_LO = 1;
    localparam int POS_LEN      = 2;
    localparam int POS_TYPE     = 3;
    localparam int POS_TAG      = 4;
    localparam int POS_SEQ      = 5;
    localparam int POS_MASK     = 6;
    localparam int DIST_BASE    = 7;
    localparam int SIG_BASE     = DIST_BASE + 2 * ANCHOR_COUNT;
    localparam int CRC_POS      = FRAME_LEN - 1;

    typedef struct packed {
        logic [2:0]         anchor_index;
        logic [15:0]        distance_mm;
        logic signed [15:0] signal_level;
        logic [7:0]         tag_id;
        logic [7:0]         fresh_bits;
    } in_item_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } out_item_t;

    typedef struct packed {
        logic clear;
        logic update;
    } crc_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SEND = 2'b10
    } state_t;

endpackage

[src/rrpf_crc_unit.sv]
module rrpf_crc_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  rrpf_pkg::crc_ctrl_t ctrl,
    input  logic [7:0]          data,
    output logic [7:0]          crc
);
    import rrpf_pkg::*;

    logic [7:0] crc_reg;
    logic [7:0] crc_next;
    logic [7:0] step;

    // one byte per cycle while ctrl.update is set, bitwise MSB-first over the byte
    always_comb
    begin
        step = crc_reg ^ data;
        for (int b = 0; b < 8; b++)
        begin
            if (step[7])
            begin
                step = {step[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                step = {step[6:0], 1'b0};
            end
        end
        if (ctrl.clear)
        begin
            crc_next = 8'h00;
        end
        else if (ctrl.update)
        begin
            crc_next = step;
        end
        else
        begin
            crc_next = crc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= 8'h00;
        end
        else
        begin
            crc_reg <= crc_next;
        end
    end

    assign crc = crc_reg;

endmodule

[src/ranging_report_packet_framer_core.sv]
// channel | direction | handshake             | payload
// in      | input     | in_valid / in_ready   | in_item  (anchor, distance, rssi, tag, mask)
// out     | output    | out_valid / out_ready | out_item (frame_byte, last_byte)
// cfg     | input     | cfg_valid / cfg_ready | cfg_data (window base tag)
//
// An item that starts no frame leaves in_ready high. The last-anchor item of a tag
// inside the window starts a frame: a byte counter walks the 32 bytes one per
// cycle unless out_ready stalls; input is held off until the CRC byte is emitted.
// Reset clears control, the sequence counters and the window base tag (to 7).
// The output register lets the next item in while the final byte waits.
module ranging_report_packet_framer_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  rrpf_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output rrpf_pkg::out_item_t out_item,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [7:0]          cfg_data
);
    import rrpf_pkg::*;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [7:0]        first_tag_reg;
    logic [7:0]        tag_reg;
    logic [7:0]        mask_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [15:0]       dist_store [ANCHOR_COUNT];
    logic [15:0]       sig_store  [ANCHOR_COUNT];
    logic [7:0]        seq_store  [TAG_SLOTS];
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_reg;

    logic              accept;
    logic              idx_ok;
    logic              is_last_idx;
    logic [8:0]        tag_diff;
    logic              in_window;
    logic              start;
    logic              emit;
    logic              frame_done;
    logic [CNT_W-1:0]  d_off;
    logic [CNT_W-1:0]  s_off;
    logic [15:0]       d_word;
    logic [15:0]       s_word;
    logic [7:0]        byte_sel;
    logic [7:0]        crc;
    crc_ctrl_t         crc_ctrl;

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = in_valid && in_ready;

    assign idx_ok      = {1'b0, in_item.anchor_index} < 4'(ANCHOR_COUNT);
    assign is_last_idx = {1'b0, in_item.anchor_index} == 4'(ANCHOR_COUNT - 1);
    assign tag_diff    = {1'b0, in_item.tag_id} - {1'b0, first_tag_reg};
    assign in_window   = !tag_diff[8] && (tag_diff < 9'(TAG_SLOTS));
    assign start       = accept && is_last_idx && in_window;

    assign emit       = (state_reg == ST_SEND) && (!out_valid_reg || out_ready);
    assign frame_done = emit && (cnt_reg == CNT_W'(CRC_POS));

    assign d_off  = cnt_reg - CNT_W'(DIST_BASE);
    assign s_off  = cnt_reg - CNT_W'(SIG_BASE);
    assign d_word = dist_store[d_off[AIDX_W:1]];
    assign s_word = sig_store[s_off[AIDX_W:1]];

    always_comb
    begin
        if (cnt_reg == CNT_W'(POS_MAGIC_HI))
        begin
            byte_sel = MAGIC_HI;
        end
        else if (cnt_reg == CNT_W'(POS_MAGIC_LO))
        begin
            byte_sel = MAGIC_LO;
        end
        else if (cnt_reg == CNT_W'(POS_LEN))
        begin
            byte_sel = 8'(PAYLOAD_LEN);
        end
        else if (cnt_reg == CNT_W'(POS_TYPE))
        begin
            byte_sel = TYPE_DATA;
        end
        else if (cnt_reg == CNT_W'(POS_TAG))
        begin
            byte_sel = tag_reg;
        end
        else if (cnt_reg == CNT_W'(POS_SEQ))
        begin
            byte_sel = seq_store[slot_reg];
        end
        else if (cnt_reg == CNT_W'(POS_MASK))
        begin
            byte_sel = mask_reg;
        end
        else if (cnt_reg < CNT_W'(SIG_BASE))
        begin
            byte_sel = d_off[0] ? d_word[15:8] : d_word[7:0];
        end
        else if (cnt_reg < CNT_W'(CRC_POS))
        begin
            byte_sel = s_off[0] ? s_word[15:8] : s_word[7:0];
        end
        else
        begin
            byte_sel = crc;
        end
    end

    assign crc_ctrl.clear  = start;
    assign crc_ctrl.update = emit && (cnt_reg >= CNT_W'(POS_LEN))
                             && (cnt_reg != CNT_W'(CRC_POS));

    rrpf_crc_unit u_crc (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (crc_ctrl),
        .data  (byte_sel),
        .crc   (crc)
    );

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SEND;
                    cnt_next   = '0;
                end
            end
            ST_SEND:
            begin
                if (frame_done)
                begin
                    state_next = ST_IDLE;
                end
                else if (emit)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            first_tag_reg <= FIRST_TAG_RESET;
            for (int i = 0; i < TAG_SLOTS; i++)
            begin
                seq_store[i] <= 8'h00;
            end
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                first_tag_reg <= cfg_data;
            end
            if (frame_done)
            begin
                seq_store[slot_reg] <= seq_store[slot_reg] + 8'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && idx_ok)
        begin
            dist_store[in_item.anchor_index[AIDX_W-1:0]] <= in_item.distance_mm;
            sig_store[in_item.anchor_index[AIDX_W-1:0]]  <= unsigned'(in_item.signal_level);
        end
        if (start)
        begin
            tag_reg  <= in_item.tag_id;
            mask_reg <= in_item.fresh_bits;
            slot_reg <= tag_diff[SLOT_W-1:0];
        end
        if (emit)
        begin
            out_reg.frame_byte <= byte_sel;
            out_reg.last_byte  <= (cnt_reg == CNT_W'(CRC_POS));
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

[verif/ranging_report_packet_framer_core_tb.sv]
module ranging_report_packet_framer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rrpf_pkg::*;

    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_LIMIT   = 2000;
    localparam int REPEAT_ITEMS  = 20;

    class frame_checker;
        logic [7:0]  first_tag;
        logic [15:0] dist_mem [ANCHOR_COUNT];
        logic [15:0] rssi_mem [ANCHOR_COUNT];
        logic [7:0]  seq_count [TAG_SLOTS];
        out_item_t   due_bytes [$];
        int          bad_count;

        function new();
            first_tag = FIRST_TAG_RESET;
            bad_count = 0;
            foreach (dist_mem[i])
            begin
                dist_mem[i] = '0;
                rssi_mem[i] = '0;
            end
            foreach (seq_count[i])
                seq_count[i] = '0;
        endfunction

        function logic [7:0] crc8(logic [7:0] crc, logic [7:0] data);
            logic [7:0] c;
            c = crc ^ data;
            for (int b = 0; b < 8; b++)
                c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
            return c;
        endfunction

        function void flag(string msg);
            bad_count++;
            if (bad_count <= 10)
                $display("mismatch: %s", msg);
        endfunction

        // stores the anchor values; a last-anchor item in the tag window queues a frame
        function void note_item(in_item_t it);
            logic [7:0] frame [FRAME_LEN];
            logic [7:0] crc;
            int         slot;
            if (it.anchor_index >= ANCHOR_COUNT)
                return;
            dist_mem[it.anchor_index] = it.distance_mm;
            rssi_mem[it.anchor_index] = it.signal_level;
            if (it.anchor_index != ANCHOR_COUNT - 1)
                return;
            slot = int'(it.tag_id) - int'(first_tag);
            if (slot < 0 || slot >= TAG_SLOTS)
                return;
            frame[POS_MAGIC_HI] = MAGIC_HI;
            frame[POS_MAGIC_LO] = MAGIC_LO;
            frame[POS_LEN]      = 8'(PAYLOAD_LEN);
            frame[POS_TYPE]     = TYPE_DATA;
            frame[POS_TAG]      = it.tag_id;
            frame[POS_SEQ]      = seq_count[slot];
            frame[POS_MASK]     = it.fresh_bits;
            for (int i = 0; i < ANCHOR_COUNT; i++)
            begin
                frame[DIST_BASE + 2 * i]     = dist_mem[i][7:0];
                frame[DIST_BASE + 2 * i + 1] = dist_mem[i][15:8];
                frame[SIG_BASE + 2 * i]      = rssi_mem[i][7:0];
                frame[SIG_BASE + 2 * i + 1]  = rssi_mem[i][15:8];
            end
            crc = 8'h00;
            for (int i = POS_LEN; i < CRC_POS; i++)
                crc = crc8(crc, frame[i]);
            frame[CRC_POS] = crc;
            seq_count[slot] = seq_count[slot] + 8'd1;
            for (int i = 0; i < FRAME_LEN; i++)
                due_bytes.push_back(out_item_t'{frame_byte: frame[i],
                                                last_byte: (i == CRC_POS)});
        endfunction

        function void check_byte(out_item_t got);
            out_item_t want;
            if (due_bytes.size() == 0)
            begin
                flag($sformatf("unexpected byte %02h last %0b",
                               got.frame_byte, got.last_byte));
                return;
            end
            want = due_bytes.pop_front();
            if (got.frame_byte !== want.frame_byte)
                flag($sformatf("frame_byte expected %02h actual %02h",
                               want.frame_byte, got.frame_byte));
            if (got.last_byte !== want.last_byte)
                flag($sformatf("last_byte expected %0b actual %0b (byte %02h)",
                               want.last_byte, got.last_byte, got.frame_byte));
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    in_item_t   in_item;
    logic       out_valid;
    logic       out_ready;
    out_item_t  out_item;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [7:0] cfg_data;

    logic in_idle;
    logic out_idle;
    int   quiet_cycles = 0;

    frame_checker frames = new();

    ranging_report_packet_framer_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            frames.check_byte(out_item);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == STALL_LIMIT)
        begin
            $display("timeout: nothing accepted for %0d cycles", STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // output back-pressure in bursts
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (out_idle && $urandom_range(0, 3) == 0)
            begin
                out_ready = 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge clk);
            end
            out_ready = 1'b1;
            repeat ($urandom_range(0, 20)) @(negedge clk);
        end
    end

    task automatic send_item(in_item_t it);
        @(negedge clk);
        if (in_idle && $urandom_range(0, 3) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        in_valid = 1'b1;
        in_item  = it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        frames.note_item(it);
    endtask

    task automatic send_fields(int idx, logic [15:0] distance, logic [15:0] rssi,
                               logic [7:0] tag, logic [7:0] mask);
        in_item_t it;
        it.anchor_index = 3'(idx);
        it.distance_mm  = distance;
        it.signal_level = rssi;
        it.tag_id       = tag;
        it.fresh_bits   = mask;
        send_item(it);
    endtask

    function automatic in_item_t make_item(int idx, logic [7:0] tag);
        in_item_t it;
        it.anchor_index = 3'(idx);
        it.distance_mm  = 16'($urandom);
        it.signal_level = 16'($urandom);
        it.tag_id       = tag;
        it.fresh_bits   = 8'($urandom);
        return it;
    endfunction

    // mostly a tag inside the window, which never wraps past 255
    function automatic logic [7:0] pick_tag();
        int span;
        span = 255 - int'(frames.first_tag);
        if (span > TAG_SLOTS - 1)
            span = TAG_SLOTS - 1;
        if ($urandom_range(0, 3) != 0)
            return frames.first_tag + 8'($urandom_range(0, span));
        return 8'($urandom);
    endfunction

    task automatic run_random(int n);
        int sent;
        int pick;
        int k;
        sent = 0;
        while (sent < n)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
            begin
                for (int i = 0; i < ANCHOR_COUNT - 1; i++)
                    send_item(make_item(i, 8'($urandom)));
                send_item(make_item(ANCHOR_COUNT - 1, pick_tag()));
                sent += ANCHOR_COUNT;
            end
            else if (pick < 9)
            begin
                k = $urandom_range(0, ANCHOR_COUNT - 2);
                repeat (k)
                    send_item(make_item($urandom_range(0, ANCHOR_COUNT - 2), 8'($urandom)));
                send_item(make_item(ANCHOR_COUNT - 1, pick_tag()));
                sent += k + 1;
            end
            else
            begin
                k = $urandom_range(0, 7);
                send_item(make_item(k, 8'($urandom)));
                if (k < ANCHOR_COUNT)
                    sent++;
            end
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (frames.due_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_first_tag(logic [7:0] value);
        wait_drained();
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        frames.first_tag = value;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_item   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        in_idle   = 1'b1;
        out_idle  = 1'b1;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // full anchor set first so no frame reads an unwritten entry
        send_fields(0, 16'h0000, 16'h8000, 8'h00, 8'h00);
        send_fields(1, 16'hFFFF, 16'h7FFF, 8'hFF, 8'hFF);
        send_fields(2, 16'h8000, 16'hFFFF, 8'h55, 8'hAA);
        send_fields(3, 16'h7FFF, 16'h0000, 8'hAA, 8'h55);
        send_fields(4, 16'h5555, 16'h2AAA, 8'h07, 8'h01);
        send_fields(5, 16'hAAAA, 16'hD555, 8'd7, 8'hFF);
        // indexes past the anchors are dropped
        send_fields(6, 16'h1234, 16'h8001, 8'd7, 8'h3C);
        send_fields(7, 16'hFFFF, 16'hFFFF, 8'd7, 8'hFF);
        // tags just outside the window
        send_fields(5, 16'h0102, 16'h0304, 8'd6, 8'h00);
        send_fields(5, 16'h0506, 16'h0708, 8'd11, 8'h0F);
        // last index alone, highest slot
        send_fields(5, 16'hFFFF, 16'h8000, 8'd10, 8'h00);
        send_fields(5, 16'h0000, 16'h7FFF, 8'd7, 8'hA5);
        send_fields(5, 16'h0001, 16'hFFFE, 8'h00, 8'hFF);
        send_fields(5, 16'hFFFE, 16'h0001, 8'hFF, 8'h80);
        send_fields(5, 16'h4000, 16'hC000, 8'd8, 8'h7F);
        send_fields(5, 16'h0400, 16'hFC00, 8'd9, 8'hFE);
        for (int i = 0; i < ANCHOR_COUNT; i++)
            send_item(make_item(i, 8'd8));

        run_random(60);
        write_first_tag(8'd0);
        run_random(20);
        write_first_tag(8'd255);
        run_random(20);
        write_first_tag(8'd252);
        run_random(20);

        // back-to-back frames on one slot
        write_first_tag(8'($urandom_range(1, 251)));
        repeat (REPEAT_ITEMS)
            send_item(make_item(ANCHOR_COUNT - 1, frames.first_tag));

        write_first_tag(FIRST_TAG_RESET);
        in_idle  = 1'b0;
        out_idle = 1'b0;
        run_random(36);

        wait_drained();
        if (frames.bad_count == 0 && frames.due_bytes.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
